// ===== rtl/core/pcd_pkg.sv =====
// ----------------------------------------------------------------------------
// Packed Cholesky package
// Shared constants, types and index helpers for the packed Cholesky block.
// ----------------------------------------------------------------------------
package pcd_pkg;

  localparam int MAX_ORDER = 8;
  localparam int TRI_SIZE  = MAX_ORDER * (MAX_ORDER + 1) / 2;
  localparam int IDX_W     = $clog2(TRI_SIZE);
  localparam int CNT_W     = $clog2(TRI_SIZE + 1);
  localparam int ORD_W     = 4;
  localparam int ROW_W     = $clog2(MAX_ORDER + 1);
  localparam int Q_SHIFT   = 24;
  localparam int ACC_W     = 64;

  localparam logic [31:0] Q_MAX = 32'h7FFF_FFFF;
  localparam logic [31:0] Q_MIN = 32'h8000_0000;

  // Register indexes on the configuration port
  localparam logic [0:0] REG_ORDER = 1'b0;

  // Command and response between the sequencer and the arithmetic unit
  typedef enum logic [1:0] {
    OP_DIV  = 2'd0,
    OP_SQRT = 2'd1
  } pcd_op_t;

  typedef struct packed {
    logic              start;
    pcd_op_t           op;
    logic signed [63:0] resid;
    logic signed [31:0] pivot;
  } pcd_cmd_t;

  typedef struct packed {
    logic        done;
    logic [31:0] result;
  } pcd_rsp_t;

  // Packed offset of the first element of a row
  function automatic logic [IDX_W-1:0] row_base(input logic [ROW_W-1:0] r);
    logic [15:0] t;
    t = 16'(r) * (16'(r) + 16'd1);
    return IDX_W'(t >> 1);
  endfunction

  // Order in use: zero maps to one, overlarge maps to the maximum
  function automatic logic [ROW_W-1:0] clamp_order(input logic [ORD_W-1:0] o);
    if (o == '0) return ROW_W'(1);
    if (32'(o) > MAX_ORDER) return ROW_W'(MAX_ORDER);
    return ROW_W'(o);
  endfunction

endpackage

// ===== rtl/core/pcd_divsqrt.sv =====
// ----------------------------------------------------------------------------
// Packed Cholesky divide / root unit
// Shared iterative unit: saturating Q8.24 quotient (one bit per cycle) or
// Q8.24 square root (one result bit per cycle).
// ----------------------------------------------------------------------------
module pcd_divsqrt (
  input  logic            clk,
  input  logic            rst_n,
  input  pcd_pkg::pcd_cmd_t cmd,
  output pcd_pkg::pcd_rsp_t rsp
);
  import pcd_pkg::*;

  logic        busy_r, busy_nxt;
  pcd_op_t     op_r, op_nxt;
  logic [5:0]  step_r, step_nxt;
  logic        neg_r, neg_nxt;
  logic [63:0] rem_r, rem_nxt;     // divide: partial remainder; root: radicand
  logic [63:0] num_r, num_nxt;     // divide: shifted numerator bits
  logic [31:0] den_r, den_nxt;
  logic [63:0] root_r, root_nxt;
  logic [63:0] bit_r, bit_nxt;
  logic [31:0] quo_r, quo_nxt;
  logic        done_r, done_nxt;
  logic [31:0] res_r, res_nxt;

  logic [63:0] ar;
  logic [64:0] trial;
  logic [63:0] rsh;

  always_comb begin
    busy_nxt = busy_r;
    op_nxt   = op_r;
    step_nxt = step_r;
    neg_nxt  = neg_r;
    rem_nxt  = rem_r;
    num_nxt  = num_r;
    den_nxt  = den_r;
    root_nxt = root_r;
    bit_nxt  = bit_r;
    quo_nxt  = quo_r;
    done_nxt = 1'b0;
    res_nxt  = res_r;
    ar       = cmd.resid[63] ? (64'd0 - 64'(cmd.resid)) : 64'(cmd.resid);
    trial    = '0;
    rsh      = '0;
    if (!busy_r) begin
      // Load a new operation; handle the saturating cases at once
      if (cmd.start) begin
        op_nxt = cmd.op;
        if (cmd.op == OP_DIV) begin
          if (cmd.pivot <= 0 || ar >= ({32'd0, cmd.pivot} << 7)) begin
            done_nxt = 1'b1;
            res_nxt  = (cmd.resid > 0) ? Q_MAX : (cmd.resid < 0) ? Q_MIN : 32'd0;
          end else begin
            // quotient < 2^31, numerator = ar << 24 (< 2^63)
            busy_nxt = 1'b1;
            neg_nxt  = cmd.resid[63];
            num_nxt  = ar << Q_SHIFT;
            den_nxt  = cmd.pivot;
            rem_nxt  = 64'd0;
            quo_nxt  = '0;
            step_nxt = 6'd63;
          end
        end else begin
          if (cmd.resid >= (64'sd1 <<< 38)) begin
            done_nxt = 1'b1;
            res_nxt  = Q_MAX;
          end else begin
            busy_nxt = 1'b1;
            rem_nxt  = 64'(cmd.resid) << Q_SHIFT;
            root_nxt = '0;
            bit_nxt  = 64'd1 << 62;
            step_nxt = 6'd31;
          end
        end
      end
    end else if (op_r == OP_DIV) begin
      // Restoring division: one numerator bit per cycle
      rsh   = {rem_r[62:0], num_r[63]};
      trial = {1'b0, rsh} - {33'd0, den_r};
      num_nxt = {num_r[62:0], 1'b0};
      if (!trial[64]) begin
        rem_nxt = trial[63:0];
        quo_nxt = {quo_r[30:0], 1'b1};
      end else begin
        rem_nxt = rsh;
        quo_nxt = {quo_r[30:0], 1'b0};
      end
      if (step_r == 6'd0) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
        res_nxt  = neg_r ? (32'd0 - quo_nxt) : quo_nxt;
      end
      step_nxt = step_r - 6'd1;
    end else begin
      // Digit-by-digit root: one result bit per cycle
      trial = {1'b0, rem_r} - {1'b0, root_r + bit_r};
      if (!trial[64]) begin
        rem_nxt  = trial[63:0];
        root_nxt = (root_r >> 1) + bit_r;
      end else begin
        root_nxt = root_r >> 1;
      end
      bit_nxt = bit_r >> 2;
      if (step_r == 6'd0) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
        res_nxt  = root_nxt[31:0];
      end
      step_nxt = step_r - 6'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
    op_r   <= op_nxt;
    step_r <= step_nxt;
    neg_r  <= neg_nxt;
    rem_r  <= rem_nxt;
    num_r  <= num_nxt;
    den_r  <= den_nxt;
    root_r <= root_nxt;
    bit_r  <= bit_nxt;
    quo_r  <= quo_nxt;
    res_r  <= res_nxt;
  end

  assign rsp.done   = done_r;
  assign rsp.result = res_r;

endmodule

// ===== rtl/core/packed_cholesky_decomposition_top.sv =====
// Throughput: load elements transfer one per cycle while the block is loading;
// each result is read from the one-port store before it is offered. The
// single divide/root unit and the one-port store set the time.
// Reset: synchronous active-low; order returns to 8, load count to 0.
// ----------------------------------------------------------------------------
// Packed Cholesky decomposition top level
// Loads a packed lower triangle, factors it in place with multiplies into one
// product register and a shared divide/root unit, and streams out the factor.
// ----------------------------------------------------------------------------
module packed_cholesky_decomposition_top (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [31:0] in_element,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] out_factor_value,
  output logic        out_not_definite,
  output logic        out_last,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [2:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);
  import pcd_pkg::*;

  typedef enum logic [11:0] {
    S_LOAD  = 12'b000000000001,
    S_ROW   = 12'b000000000010,
    S_RDA   = 12'b000000000100,
    S_RDB   = 12'b000000001000,
    S_MAC   = 12'b000000010000,
    S_RDP   = 12'b000000100000,
    S_CALC  = 12'b000001000000,
    S_WAIT  = 12'b000010000000,
    S_WR    = 12'b000100000000,
    S_RDOUT = 12'b001000000000,
    S_OUT   = 12'b010000000000,
    S_SQ    = 12'b100000000000
  } state_t;

  state_t state_r, state_nxt;

  logic [ORD_W-1:0] order_r, order_nxt;
  logic [CNT_W-1:0] load_r, load_nxt;
  logic [ROW_W-1:0] j_r, j_nxt, k_r, k_nxt, i_r, i_nxt;
  logic signed [63:0] s_r, s_nxt, d_r, d_nxt;
  logic signed [31:0] a_r, a_nxt;
  logic signed [63:0] prod_r, prod_nxt;
  logic [IDX_W-1:0] oidx_r, oidx_nxt;
  logic             err_r, err_nxt;
  logic             ov_r, ov_nxt;
  logic [31:0]      ofv_r, ofv_nxt;
  logic             olast_r, olast_nxt;
  logic             prod_v_r, prod_v_nxt;

  // Single-port store
  logic [31:0]      mem [TRI_SIZE];
  logic             we;
  logic [IDX_W-1:0] addr;
  logic [31:0]      wdata, rdata_r;

  pcd_cmd_t cmd;
  pcd_rsp_t rsp;

  logic [ROW_W-1:0] n_use;
  logic [CNT_W-1:0] total;
  logic             cfg_wr;
  logic             in_xfer, out_xfer;
  logic signed [63:0] resid;

  assign n_use   = clamp_order(order_r);
  assign total   = CNT_W'(row_base(n_use));
  assign cfg_wr  = cfg_psel && cfg_penable && cfg_pwrite &&
                   (cfg_paddr[2] == REG_ORDER);
  assign in_ready  = (state_r == S_LOAD);
  assign in_xfer   = in_valid && in_ready;
  assign out_xfer  = out_valid && out_ready;
  assign cfg_pready = 1'b1;
  assign cfg_prdata = (cfg_paddr[2] == REG_ORDER) ? {28'd0, order_r} : 32'd0;

  assign out_valid        = ov_r;
  assign out_factor_value = ofv_r;
  assign out_not_definite = err_r;
  assign out_last         = olast_r;

  pcd_divsqrt u_divsqrt (
    .clk  (clk),
    .rst_n(rst_n),
    .cmd  (cmd),
    .rsp  (rsp)
  );

  always_ff @(posedge clk) begin
    if (we) mem[addr] <= wdata;
    rdata_r <= mem[addr];
  end

  always_comb begin
    state_nxt  = state_r;
    order_nxt  = order_r;
    load_nxt   = load_r;
    j_nxt = j_r; k_nxt = k_r; i_nxt = i_r;
    s_nxt = s_r; d_nxt = d_r; a_nxt = a_r;
    prod_v_nxt = 1'b0;
    prod_nxt   = prod_r;
    oidx_nxt   = oidx_r;
    err_nxt    = err_r;
    ov_nxt     = ov_r;
    ofv_nxt    = ofv_r;
    olast_nxt  = olast_r;
    we    = 1'b0;
    addr  = IDX_W'(load_r);
    wdata = in_element;
    cmd.start = 1'b0;
    cmd.op    = OP_DIV;
    cmd.resid = s_r;
    cmd.pivot = rdata_r;
    resid     = '0;

    // Drop a finished result
    if (out_xfer) ov_nxt = 1'b0;

    // Accumulate each valid product after the multiply register
    if (prod_v_r) s_nxt = s_r + (prod_r >>> Q_SHIFT);

    if (cfg_wr) begin
      order_nxt = cfg_pwdata[ORD_W-1:0];
      load_nxt  = '0;
    end

    unique case (state_r)
      S_LOAD: begin
        if (in_xfer) begin
          we = 1'b1;
          if (load_r + 1'b1 >= total) begin
            load_nxt  = '0;
            j_nxt     = '0;
            state_nxt = S_ROW;
          end else begin
            load_nxt = load_r + 1'b1;
          end
        end
      end
      // Start row j at column 0
      S_ROW: begin
        k_nxt = '0; i_nxt = '0; s_nxt = '0; d_nxt = '0;
        state_nxt = (j_r == '0) ? S_RDP : S_RDA;
        if (j_r == '0) k_nxt = '0;
      end
      // Inner product: read L(k,i), then L(j,i)
      S_RDA: begin
        if (i_r == k_r) begin
          state_nxt = S_RDP;
        end else begin
          addr = row_base(k_r) + IDX_W'(i_r);
          state_nxt = S_RDB;
        end
      end
      S_RDB: begin
        a_nxt = rdata_r;
        addr  = row_base(j_r) + IDX_W'(i_r);
        state_nxt = S_MAC;
      end
      S_MAC: begin
        prod_nxt   = a_r * $signed(rdata_r);
        prod_v_nxt = 1'b1;
        i_nxt      = i_r + 1'b1;
        state_nxt  = S_RDA;
      end
      // Read A(j,k) and the pivot L(k,k) (or A(j,j) on the diagonal);
      // hold a diagonal while an earlier result still owns the output register
      S_RDP: begin
        if (!prod_v_r && (k_r != j_r || !ov_r || out_xfer)) begin
          addr = row_base(j_r) + IDX_W'(k_r);
          state_nxt = S_CALC;
        end
      end
      S_CALC: begin
        a_nxt = rdata_r;
        if (k_r == j_r) begin
          resid = 64'($signed(rdata_r)) - d_r;
          if (resid < 0) begin
            err_nxt   = 1'b1;
            ofv_nxt   = '0;
            olast_nxt = 1'b1;
            ov_nxt    = 1'b1;
            state_nxt = S_OUT;
          end else begin
            cmd.start = 1'b1;
            cmd.op    = OP_SQRT;
            cmd.resid = resid;
            state_nxt = S_WAIT;
          end
        end else begin
          s_nxt = 64'($signed(rdata_r)) - s_r;
          addr  = row_base(k_r) + IDX_W'(k_r);
          state_nxt = S_WR;
        end
      end
      // Issue the divide once the pivot read lands
      S_WR: begin
        cmd.start = 1'b1;
        cmd.op    = OP_DIV;
        cmd.resid = s_r;
        cmd.pivot = rdata_r;
        state_nxt = S_WAIT;
      end
      S_WAIT: begin
        if (rsp.done) begin
          we    = 1'b1;
          addr  = row_base(j_r) + IDX_W'(k_r);
          wdata = rsp.result;
          if (k_r == j_r) begin
            if (j_r + 1'b1 == n_use) begin
              oidx_nxt  = '0;
              err_nxt   = 1'b0;
              state_nxt = S_RDOUT;
            end else begin
              j_nxt     = j_r + 1'b1;
              state_nxt = S_ROW;
            end
          end else begin
            // Square of the new entry joins the diagonal sum
            prod_nxt   = $signed(rsp.result) * $signed(rsp.result);
            k_nxt      = k_r + 1'b1;
            i_nxt      = '0;
            state_nxt  = S_SQ;
          end
        end
      end
      S_SQ: begin
        d_nxt = d_r + (prod_r >>> Q_SHIFT);
        s_nxt = '0;
        state_nxt = S_RDA;
      end
      // Stream the factor out of the store
      S_RDOUT: begin
        if (!ov_r || out_xfer) begin
          addr = oidx_r;
          state_nxt = S_OUT;
        end
      end
      S_OUT: begin
        if (err_r) begin
          if (out_xfer) begin
            err_nxt   = 1'b0;
            state_nxt = S_LOAD;
          end
        end else if (!ov_r || out_xfer) begin
          ofv_nxt   = rdata_r;
          ov_nxt    = 1'b1;
          olast_nxt = (CNT_W'(oidx_r) + 1'b1 == total);
          if (CNT_W'(oidx_r) + 1'b1 == total) begin
            state_nxt = S_LOAD;
          end else begin
            oidx_nxt  = oidx_r + 1'b1;
            state_nxt = S_RDOUT;
          end
        end
      end
      default: state_nxt = S_LOAD;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_LOAD;
      order_r  <= ORD_W'(MAX_ORDER);
      load_r   <= '0;
      ov_r     <= 1'b0;
      err_r    <= 1'b0;
      prod_v_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      order_r  <= order_nxt;
      load_r   <= load_nxt;
      ov_r     <= ov_nxt;
      err_r    <= err_nxt;
      prod_v_r <= prod_v_nxt;
    end
    j_r <= j_nxt; k_r <= k_nxt; i_r <= i_nxt;
    s_r <= s_nxt; d_r <= d_nxt; a_r <= a_nxt;
    prod_r <= prod_nxt; oidx_r <= oidx_nxt;
    ofv_r <= ofv_nxt; olast_r <= olast_nxt;
  end

  a_ready_load: assert property (@(posedge clk) disable iff (!rst_n)
    in_ready |-> !out_valid || out_ready || out_last)
    else $error("input taken while results still stream");
  a_err_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_not_definite |-> out_last)
    else $error("error result without last");
  a_load_bound: assert property (@(posedge clk) disable iff (!rst_n)
    load_r < total || load_r == '0 || $past(cfg_wr))
    else $error("load count past the triangle");
endmodule

// ===== bench/packed_cholesky_decomposition_chk.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Packed Cholesky checker
// Watches the load, result and register channels, predicts the factor of
// every completed load in Q8.24 and compares each result transfer in order.
// ----------------------------------------------------------------------------
module packed_cholesky_decomposition_chk (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_ready,
  input  logic [31:0] in_element,
  input  logic        out_valid,
  input  logic        out_ready,
  input  logic [31:0] out_factor_value,
  input  logic        out_not_definite,
  input  logic        out_last,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [2:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  input  logic        cfg_pready,
  output int          fail_count,
  output int          pending
);
  import pcd_pkg::*;

  typedef struct packed {
    logic [31:0] value;
    logic        not_definite;
    logic        last;
  } factor_res_t;

  logic signed [31:0] tri_store [TRI_SIZE];
  logic [ORD_W-1:0]   order_reg;
  int                 loaded;
  factor_res_t        factor_q[$];
  int                 errors;

  // Q8.24 product, floored back to Q.24
  function automatic longint mul_q24(input logic signed [31:0] a, input logic signed [31:0] b);
    longint p;
    p = longint'(a) * longint'(b);
    return p >>> Q_SHIFT;
  endfunction

  // Saturating quotient residual / pivot
  function automatic logic [31:0] quot_q24(input longint r, input logic signed [31:0] p);
    logic [63:0] ar;
    logic [63:0] q;
    if (p <= 0) begin
      if (r > 0) return Q_MAX;
      if (r < 0) return Q_MIN;
      return 32'd0;
    end
    ar = (r < 0) ? 64'(-r) : 64'(r);
    if (ar >= (64'($unsigned(p)) << 7)) return (r < 0) ? Q_MIN : Q_MAX;
    q = (ar << Q_SHIFT) / 64'($unsigned(p));
    if (r < 0) return 32'(-q);
    return q[31:0];
  endfunction

  // Floor root of residual in Q8.24
  function automatic logic [31:0] root_q24(input longint r);
    logic [63:0] x;
    logic [63:0] rt;
    logic [63:0] b;
    if (r >= (longint'(1) << 38)) return Q_MAX;
    x  = 64'(r) << Q_SHIFT;
    rt = '0;
    b  = 64'h4000_0000_0000_0000;
    while (b > x) b = b >> 2;
    while (b != 0) begin
      if (x >= rt + b) begin
        x  = x - (rt + b);
        rt = (rt >> 1) + b;
      end else begin
        rt = rt >> 1;
      end
      b = b >> 2;
    end
    return rt[31:0];
  endfunction

  // Factor the store in place; returns 0 on a negative diagonal residual
  function automatic bit factor_store(input int n);
    int     jb;
    int     kb;
    longint d;
    longint s;
    for (int j = 0; j < n; j++) begin
      jb = j * (j + 1) / 2;
      d  = 0;
      for (int k = 0; k < j; k++) begin
        kb = k * (k + 1) / 2;
        s  = 0;
        for (int i = 0; i < k; i++) s += mul_q24(tri_store[kb + i], tri_store[jb + i]);
        tri_store[jb + k] = quot_q24(longint'(tri_store[jb + k]) - s, tri_store[kb + k]);
        d += mul_q24(tri_store[jb + k], tri_store[jb + k]);
      end
      d = longint'(tri_store[jb + j]) - d;
      if (d < 0) return 1'b0;
      tri_store[jb + j] = root_q24(d);
    end
    return 1'b1;
  endfunction

  // Take one load element; queue the factor when the triangle is complete
  function automatic void predict_load(input logic [31:0] v);
    int n;
    int total;
    n     = (order_reg == 0) ? 1 : (int'(order_reg) > MAX_ORDER) ? MAX_ORDER : int'(order_reg);
    total = n * (n + 1) / 2;
    if (loaded >= total) loaded = 0;
    tri_store[loaded] = v;
    loaded++;
    if (loaded < total) return;
    loaded = 0;
    if (!factor_store(n)) begin
      factor_q.push_back('{32'd0, 1'b1, 1'b1});
    end else begin
      for (int e = 0; e < total; e++)
        factor_q.push_back('{tri_store[e], 1'b0, (e == total - 1)});
    end
  endfunction

  // Compare one result transfer with the oldest expectation
  function automatic void check_result();
    factor_res_t x;
    if (factor_q.size() == 0) begin
      $error("unexpected result transfer: factor_value %h", out_factor_value);
      errors++;
      return;
    end
    x = factor_q.pop_front();
    if (out_factor_value !== x.value) begin
      $error("factor_value expected %h actual %h", x.value, out_factor_value);
      errors++;
    end
    if (out_not_definite !== x.not_definite) begin
      $error("not_definite expected %b actual %b", x.not_definite, out_not_definite);
      errors++;
    end
    if (out_last !== x.last) begin
      $error("last expected %b actual %b", x.last, out_last);
      errors++;
    end
  endfunction

  // Track register writes, compare results, predict loads
  always @(posedge clk) begin
    if (!rst_n) begin
      order_reg = ORD_W'(MAX_ORDER);
      loaded    = 0;
      factor_q.delete();
    end else begin
      if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready && cfg_paddr[2] == REG_ORDER) begin
        order_reg = cfg_pwdata[ORD_W-1:0];
        loaded    = 0;
      end
      if (out_valid && out_ready) check_result();
      if (in_valid && in_ready) predict_load(in_element);
    end
    fail_count <= errors;
    pending    <= factor_q.size();
  end

endmodule

// ===== bench/packed_cholesky_decomposition_top_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Packed Cholesky testbench top
// Drives directed and random packed triangles at several orders with random
// gaps on both channels, one long result stall, and reports the verdict.
// ----------------------------------------------------------------------------
module packed_cholesky_decomposition_top_tb;
  import pcd_pkg::*;

  localparam logic [2:0]  ADDR_ORDER = {REG_ORDER, 2'b00};
  localparam logic [2:0]  ADDR_SPARE = 3'd4;
  localparam logic [31:0] ONE_Q      = 32'h0100_0000;
  localparam int          LIMIT      = 2000000;
  localparam int          ITEMS      = 480;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [31:0] in_element = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [31:0] out_factor_value;
  logic        out_not_definite;
  logic        out_last;
  logic        cfg_psel = 1'b0;
  logic        cfg_penable = 1'b0;
  logic        cfg_pwrite = 1'b0;
  logic [2:0]  cfg_paddr = '0;
  logic [31:0] cfg_pwdata = '0;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;

  int fail_count;
  int pending;
  int sent = 0;
  int cycles = 0;
  int hold_left = 0;
  bit calm = 1'b0;
  bit hold_ask = 1'b0;
  bit hold_taken = 1'b0;
  int cur_n = MAX_ORDER;

  packed_cholesky_decomposition_top dut (.*);

  packed_cholesky_decomposition_chk chk (
    .clk, .rst_n, .in_valid, .in_ready, .in_element,
    .out_valid, .out_ready, .out_factor_value, .out_not_definite, .out_last,
    .cfg_psel, .cfg_penable, .cfg_pwrite, .cfg_paddr, .cfg_pwdata, .cfg_pready,
    .fail_count, .pending
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Watchdog
  always @(posedge clk) begin
    cycles++;
    if (cycles > LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  // Result side: random backpressure, one long hold-off on request
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else if (hold_left > 0) begin
      out_ready <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (hold_ask && !hold_taken) begin
      hold_taken <= 1'b1;
      hold_left  <= 6000;
      out_ready  <= 1'b0;
    end else begin
      out_ready <= calm || ($urandom_range(99) >= 24);
    end
  end

  // Offer one element and hold it until transfer, then maybe idle
  task automatic put_element(input logic [31:0] v);
    in_valid   <= 1'b1;
    in_element <= v;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sent++;
    if (!calm && $urandom_range(99) < 24) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
  endtask

  // Stop offering and wait until every expected result has transferred
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  // Two-phase register write
  task automatic reg_write(input logic [2:0] addr, input logic [31:0] data);
    cfg_psel    <= 1'b1;
    cfg_pwrite  <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_paddr   <= addr;
    cfg_pwdata  <= data;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
  endtask

  task automatic set_order(input logic [3:0] o);
    reg_write(ADDR_ORDER, 32'(o) | ($urandom & 32'hFFFF_FFF0));
    cur_n = (o == 0) ? 1 : (int'(o) > MAX_ORDER) ? MAX_ORDER : int'(o);
  endtask

  // One load: dominant diagonal (definite), raw noise, or a dropped partial
  task automatic put_triangle(input int kind);
    int          total;
    int          shr;
    logic [31:0] v;
    total = cur_n * (cur_n + 1) / 2;
    shr   = $urandom_range(0, 8);
    if (kind == 2) begin
      repeat ($urandom_range(1, total)) put_element($urandom);
      drain();
      set_order(4'(cur_n));
      return;
    end
    for (int j = 0; j < cur_n; j++) begin
      for (int k = 0; k <= j; k++) begin
        if (kind == 1) v = $urandom;
        else if (k == j) v = (32'(cur_n) << 24) + $urandom_range(0, ONE_Q);
        else v = $urandom_range(0, 2 * ONE_Q - 2) - (ONE_Q - 1);
        if (kind == 0) v = $signed(v) >>> shr;
        put_element(v);
      end
    end
  endtask

  initial begin
    int kind;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Order one: extremes, negative, zero, plain root
    set_order(4'd1);
    put_element(32'h7FFF_FFFF);
    put_element(32'h8000_0000);
    put_element(32'h0000_0000);
    put_element(32'h0400_0000);
    drain();

    // Order two: zero pivot, zero residual, quotient overflow both signs
    set_order(4'd2);
    put_element(32'd0); put_element(ONE_Q); put_element(ONE_Q);
    put_element(32'd0); put_element(32'd0); put_element(ONE_Q);
    put_element(32'd1); put_element(32'h6400_0000); put_element(32'h7F00_0000);
    put_element(32'd1); put_element(32'h9C00_0000); put_element(32'h7F00_0000);
    drain();

    // Partial load dropped by an order write, then unused address, order zero
    set_order(4'd3);
    put_element(ONE_Q); put_element(32'd5);
    drain();
    set_order(4'd2);
    put_triangle(0);
    drain();
    reg_write(ADDR_SPARE, 32'hFFFF_FFFF);
    put_triangle(0);
    drain();
    set_order(4'd0);
    put_element(32'h0900_0000);
    drain();

    // Fill the block while results are held off
    set_order(4'd15);
    hold_ask = 1'b1;
    repeat (3) put_triangle(0);
    drain();

    // Random phases
    while (sent < ITEMS) begin
      calm = (sent > 220 && sent < 320);
      if ($urandom_range(99) < 70) set_order(4'($urandom_range(1, 4)));
      else set_order(4'($urandom_range(0, 15)));
      repeat ($urandom_range(1, 3)) begin
        kind = $urandom_range(99);
        put_triangle(kind < 70 ? 0 : (kind < 88 ? 1 : 2));
      end
      drain();
    end
    calm = 1'b0;

    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/core/pcd_pkg.sv
rtl/core/pcd_divsqrt.sv
rtl/core/packed_cholesky_decomposition_top.sv
bench/packed_cholesky_decomposition_chk.sv
bench/packed_cholesky_decomposition_top_tb.sv
